// File: hdl/adsr_pkg.sv
// Shared types, constants and codes for the ADSR envelope scaler.
`timescale 1ns / 1ps

package adsr_pkg;

    // Field and register widths
    localparam int SMP_W      = 16;
    localparam int LVL_W      = 25;
    localparam int PH_W       = 3;
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 16;
    localparam int FRAC_W     = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Output stream word: sample, level, phase, padded to whole bytes
    localparam int OUT_USED_W  = SMP_W + LVL_W + PH_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Divider geometry: dividend < divisor * 2^DIV_Q_W always holds
    localparam int DIV_Q_W = LVL_W;
    localparam int DIV_D_W = TIME_W;
    localparam int DIV_N_W = DIV_Q_W + DIV_D_W;

    // Unity gain in 1.24
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << FRAC_W;

    // Envelope phase codes
    localparam logic [PH_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PH_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PH_W-1:0] PH_DECAY   = 3'd2;
    localparam logic [PH_W-1:0] PH_SUSTAIN = 3'd3;
    localparam logic [PH_W-1:0] PH_RELEASE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP    = 3'd4;

    // Configuration reset values
    localparam logic [TIME_W-1:0] ATTACK_RST  = 32'd8388608;
    localparam logic [TIME_W-1:0] DECAY_RST   = 32'd1677722;
    localparam logic [LVL_W-1:0]  SUSTAIN_RST = 25'd6710886;
    localparam logic [TIME_W-1:0] RELEASE_RST = 32'd16777216;
    localparam logic [STEP_W-1:0] STEP_RST    = 16'd380;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // take request, apply gate and phase cascade
        logic dec_mul;    // form decay numerator product
        logic div_start;  // launch divider for current phase
        logic set_level;  // level straight from phase (sustain, idle)
        logic post;       // finish level from quotient
        logic rel_level;  // take release level from product
        logic scale;      // multiply sample by level
        logic emit;       // load output register, advance time
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic            div_done;
        logic            out_free;
    } t_dp_sts;

endpackage

// File: hdl/adsr_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module adsr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [adsr_pkg::DIV_N_W-1:0]   i_dividend,
    input  logic [adsr_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [adsr_pkg::DIV_Q_W-1:0]   o_quotient
);
    import adsr_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_Q_W-1:0] r_low;
    logic [DIV_D_W-1:0] r_div;

    logic [DIV_D_W:0]   w_trial;
    logic [DIV_D_W:0]   w_diff;
    logic               w_ge;
    logic [DIV_D_W-1:0] n_rem;

    // Trial subtract of the next partial remainder
    always_comb begin
        w_trial = {r_rem, r_low[DIV_Q_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
    end

    // Hold busy flag and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_Q_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Shift dividend bits in, quotient bits out at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DIV_N_W-1:DIV_Q_W];
            r_low <= i_dividend[DIV_Q_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[DIV_Q_W-2:0], w_ge};
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_low;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

// File: hdl/adsr_datapath.sv
// Envelope state, configuration registers, divider and scaling datapath.
`timescale 1ns / 1ps

module adsr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  adsr_pkg::t_dp_cmd                   i_cmd,
    output adsr_pkg::t_dp_sts                   o_sts,
    input  logic                                i_cfg_we,
    input  logic [adsr_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [adsr_pkg::SMP_W-1:0]          i_in_sample,
    input  logic                                i_gate,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [adsr_pkg::OUT_TDATA_W-1:0]    o_out_data
);
    import adsr_pkg::*;

    // Configuration
    logic [TIME_W-1:0] r_attack;
    logic [TIME_W-1:0] r_decay;
    logic [LVL_W-1:0]  r_sustain;
    logic [TIME_W-1:0] r_release;
    logic [STEP_W-1:0] r_step;

    // Envelope state
    logic [PH_W-1:0]   r_phase;
    logic [TIME_W-1:0] r_elapsed;
    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  r_rel_start;

    // Working registers
    logic [SMP_W-1:0]   r_sample;
    logic [DIV_N_W-1:0] r_prod;
    logic [SMP_W-1:0]   r_scaled;

    // Output register
    logic              r_out_valid;
    logic [SMP_W-1:0]  r_out_sample;
    logic [LVL_W-1:0]  r_out_level;
    logic [PH_W-1:0]   r_out_phase;

    logic [LVL_W-1:0]       w_sus_sat;
    logic [PH_W-1:0]        w_ph;
    logic [TIME_W-1:0]      w_el;
    logic [LVL_W-1:0]       w_rs;
    logic [DIV_N_W-1:0]     w_dividend;
    logic [DIV_D_W-1:0]     w_divisor;
    logic                   w_div_done;
    logic [DIV_Q_W-1:0]     w_quot;
    logic [DIV_N_W-1:0]     w_dec_prod;
    logic [2*LVL_W-1:0]     w_rel_prod;
    logic signed [SMP_W+LVL_W:0] w_scaled;
    logic [TIME_W:0]        w_el_sum;
    logic [TIME_W-1:0]      w_el_next;
    logic                   w_timed;

    assign w_sus_sat = (r_sustain > LVL_ONE) ? LVL_ONE : r_sustain;

    // Apply gate edge, then cascade through phases whose length is reached
    always_comb begin
        w_ph = r_phase;
        w_el = r_elapsed;
        w_rs = r_rel_start;
        if (!i_gate && (r_phase == PH_ATTACK || r_phase == PH_DECAY ||
                        r_phase == PH_SUSTAIN)) begin
            w_rs = r_level;
            w_el = '0;
            w_ph = PH_RELEASE;
        end else if (i_gate && (r_phase == PH_IDLE || r_phase == PH_RELEASE)) begin
            w_ph = PH_ATTACK;
            w_el = '0;
        end
        if (w_ph == PH_ATTACK && w_el >= r_attack) begin
            w_ph = PH_DECAY;
            w_el = '0;
        end
        if (w_ph == PH_DECAY && w_el >= r_decay) begin
            w_ph = PH_SUSTAIN;
            w_el = '0;
        end
        if (w_ph == PH_RELEASE && w_el >= r_release) begin
            w_ph = PH_IDLE;
        end
    end

    // Select divider operands by phase
    always_comb begin
        w_dividend = DIV_N_W'({r_elapsed, {FRAC_W{1'b0}}});
        w_divisor  = r_release;
        if (r_phase == PH_DECAY) begin
            w_dividend = r_prod;
            w_divisor  = r_decay;
        end else if (r_phase == PH_ATTACK) begin
            w_divisor = r_attack;
        end
    end

    adsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Products
    assign w_dec_prod = DIV_N_W'(LVL_ONE - w_sus_sat) * DIV_N_W'(r_elapsed);
    assign w_rel_prod = (2*LVL_W)'(r_rel_start) * (2*LVL_W)'(LVL_ONE - w_quot);
    assign w_scaled   = $signed(r_sample) * $signed({1'b0, r_level});

    // Saturating time advance
    assign w_el_sum  = {1'b0, r_elapsed} + (TIME_W+1)'(r_step);
    assign w_el_next = w_el_sum[TIME_W] ? {TIME_W{1'b1}} : w_el_sum[TIME_W-1:0];
    assign w_timed   = (r_phase == PH_ATTACK) || (r_phase == PH_DECAY) ||
                       (r_phase == PH_RELEASE);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= ATTACK_RST;
            r_decay   <= DECAY_RST;
            r_sustain <= SUSTAIN_RST;
            r_release <= RELEASE_RST;
            r_step    <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ATTACK:  r_attack  <= i_cfg_data[TIME_W-1:0];
                REG_DECAY:   r_decay   <= i_cfg_data[TIME_W-1:0];
                REG_SUSTAIN: r_sustain <= i_cfg_data[LVL_W-1:0];
                REG_RELEASE: r_release <= i_cfg_data[TIME_W-1:0];
                REG_STEP:    r_step    <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Envelope state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_level     <= '0;
            r_rel_start <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_phase     <= w_ph;
                r_elapsed   <= w_el;
                r_rel_start <= w_rs;
            end
            if (i_cmd.set_level) begin
                r_level <= (r_phase == PH_SUSTAIN) ? w_sus_sat : '0;
            end
            if (i_cmd.post && r_phase == PH_ATTACK) begin
                r_level <= w_quot;
            end
            if (i_cmd.post && r_phase == PH_DECAY) begin
                r_level <= LVL_ONE - w_quot;
            end
            if (i_cmd.rel_level) begin
                r_level <= r_prod[FRAC_W +: LVL_W];
            end
            if (i_cmd.emit && w_timed) begin
                r_elapsed <= w_el_next;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_in_sample;
        end
        if (i_cmd.dec_mul) begin
            r_prod <= w_dec_prod;
        end
        if (i_cmd.post) begin
            r_prod <= DIV_N_W'(w_rel_prod);
        end
        if (i_cmd.scale) begin
            r_scaled <= w_scaled[FRAC_W +: SMP_W];
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sample <= r_scaled;
            r_out_level  <= r_level;
            r_out_phase  <= r_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_TDATA_W'({r_out_phase, r_out_level, r_out_sample});

    assign o_sts.phase    = r_phase;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emitted result not presented");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_ONE)
        else $error("envelope level above unity");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> (w_divisor != '0))
        else $error("divider started with zero divisor");

    a_hold_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (r_phase == PH_SUSTAIN || r_phase == PH_IDLE))
            |=> $stable(r_elapsed))
        else $error("elapsed time moved in an untimed phase");

endmodule

// File: hdl/adsr_ctrl.sv
// Sequencing state machine for the ADSR envelope scaler.
`timescale 1ns / 1ps

module adsr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  adsr_pkg::t_dp_sts  i_sts,
    output adsr_pkg::t_dp_cmd  o_cmd
);
    import adsr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DLOAD = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;
    localparam logic [2:0] ST_RLVL  = 3'd5;
    localparam logic [2:0] ST_SCALE = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                unique case (i_sts.phase)
                    PH_ATTACK, PH_RELEASE: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end
                    PH_DECAY: begin
                        o_cmd.dec_mul = 1'b1;
                        n_state       = ST_DLOAD;
                    end
                    default: begin
                        o_cmd.set_level = 1'b1;
                        n_state         = ST_SCALE;
                    end
                endcase
            end
            ST_DLOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                o_cmd.post = 1'b1;
                n_state    = (i_sts.phase == PH_RELEASE) ? ST_RLVL : ST_SCALE;
            end
            ST_RLVL: begin
                o_cmd.rel_level = 1'b1;
                n_state         = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/adsr_envelope_scaler.sv
// Top level of the ADSR envelope scaler: controller plus datapath.
//
//  Channel   Direction  Payload (low bit first)                    Handshake
//  s_axis    in         tdata: in_sample[15:0]; tuser: gate        tvalid/tready
//  m_axis    out        tdata: out_sample[15:0], envelope_level    tvalid/tready
//                              [40:16], phase[43:41], zero pad
//  cfg       in         i_cfg_addr register index, i_cfg_data      i_cfg_we
//
//  A request passes IDLE, PREP, DIV, POST, SCALE and OUT in attack, with
//  DLOAD added in decay and RLVL in release, and only PREP, SCALE and OUT
//  in sustain and idle; the restoring divider that forms the level dominates.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A stalled output holds its result; the next request is accepted while
//  it waits and stops only before the output register is reloaded.
`timescale 1ns / 1ps

module adsr_envelope_scaler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [adsr_pkg::SMP_W-1:0]          s_axis_tdata,  // in_sample
    input  logic                                s_axis_tuser,  // gate
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_sample, envelope_level, phase, zero pad
    output logic [adsr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [adsr_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import adsr_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    adsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    adsr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_sample (s_axis_tdata),
        .i_gate      (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
